>>> hdl/scm_pkg.sv
// ----------------------------------------------------------------------------
// SysEx message checker package
// Shared types and constants for the SysEx message checker.
// ----------------------------------------------------------------------------
package scm_pkg;

   localparam int HEADER_REG_BITS = 40;
   localparam int HEADER_SLOT_BITS = 64;
   localparam int CSR_DATA_BITS = 40;
   localparam int CSR_INDEX_BITS = 3;
   localparam int OUT_LENGTH_BITS = 11;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [OUT_LENGTH_BITS-1:0] MAX_REPORT_LENGTH = 11'h7ff;
   localparam logic [7:0] LOW_NIBBLE_MASK = 8'h0f;
   localparam logic [7:0] DATA_MASK = 8'h7f;

   localparam logic [1:0] ID_MODE_NONE = 2'd0;
   localparam logic [1:0] ID_MODE_BYTE = 2'd1;
   localparam logic [1:0] ID_MODE_NIBBLE = 2'd2;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_HEADER_BYTES,
      REG_HEADER_LENGTH,
      REG_DEVICE_ID_MODE,
      REG_DEVICE_ID,
      REG_EXPECTED_CMD,
      REG_FIELD_POSITIONS,
      REG_EXPECTED_FIELDS,
      REG_CHECKSUM_SETUP
   } reg_index_type;

   typedef struct packed {
      logic [HEADER_REG_BITS-1:0] header_bytes;
      logic [2:0]                 header_length;
      logic [1:0]                 device_id_mode;
      logic [7:0]                 device_id;
      logic [7:0]                 expected_cmd;
      logic [15:0]                field_positions;
      logic [26:0]                expected_fields;
      logic [23:0]                checksum_setup;
   } config_type;

   // all registers clear except the device id, which starts as ignore
   localparam config_type CFG_RESET = {
      40'h0, 3'd0, 2'd0, 8'hff, 8'h00, 16'h0000, 27'h0, 24'h0
   };

   typedef struct packed {
      logic header_valid;
      logic command_valid;
      logic checksum_valid;
      logic [OUT_LENGTH_BITS-1:0] message_length;
   } result_type;

endpackage

>>> hdl/scm_queue.sv
// ----------------------------------------------------------------------------
// SysEx checker item queue
// Small register FIFO between the front and back sections.
// ----------------------------------------------------------------------------
module scm_queue #(
   parameter int WIDTH = 21,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    slot_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign push_ready = (count_ff != CNT_BITS'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> hdl/scm_front.sv
// ----------------------------------------------------------------------------
// SysEx checker front section
// Accepts bytes, tracks the byte index and tags each item for the back.
// ----------------------------------------------------------------------------
module scm_front #(
   parameter int LENGTH_BITS = 11
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [7:0]                  req_message_byte,
   input  logic                        req_last_byte,
   output logic                        push_valid,
   input  logic                        push_ready,
   output logic [LENGTH_BITS+9:0]      push_data
);

   localparam logic [LENGTH_BITS-1:0] COUNT_LIMIT = '1;

   logic [LENGTH_BITS-1:0] index_ff, index_in;
   logic                   counted;
   logic                   accept;

   assign req_ready  = push_ready;
   assign push_valid = req_valid;
   assign accept     = req_valid && push_ready;
   assign counted    = (index_ff != COUNT_LIMIT);
   assign push_data  = {counted, req_last_byte, req_message_byte, index_ff};

   always_comb begin
      index_in = index_ff;
      if (accept) begin
         if (req_last_byte) begin
            index_in = '0;
         end else if (counted) begin
            index_in = index_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff <= '0;
      end else begin
         index_ff <= index_in;
      end
   end

endmodule

>>> hdl/scm_back.sv
// ----------------------------------------------------------------------------
// SysEx checker back section
// Runs header, field and checksum checks per byte and registers the result.
// ----------------------------------------------------------------------------
module scm_back #(
   parameter int MAX_HEADER_BYTES = 5,
   parameter int LENGTH_BITS = 11
) (
   input  logic                      clock,
   input  logic                      reset,
   input  scm_pkg::config_type       cfg,
   input  logic                      pop_valid,
   output logic                      pop_ready,
   input  logic [LENGTH_BITS+9:0]    pop_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output scm_pkg::result_type       rsp_result
);

   localparam int CW = (LENGTH_BITS > 12) ? LENGTH_BITS : 12;
   localparam int LW = (LENGTH_BITS > scm_pkg::OUT_LENGTH_BITS) ?
                       LENGTH_BITS : scm_pkg::OUT_LENGTH_BITS;

   logic [LENGTH_BITS-1:0] idx;
   logic [7:0]             data_byte;
   logic                   last, counted, take;

   logic header_match_ff, header_match_in;
   logic fields_match_ff, fields_match_in;
   logic command_seen_ff, command_seen_in;
   logic [7:0] sum_ff, sum_in;
   logic sum_match_ff, sum_match_in;
   logic rsp_valid_ff, rsp_valid_in;
   scm_pkg::result_type result_ff, result_in;

   logic [3:0]  hl;
   logic [4:0]  need;
   logic [scm_pkg::HEADER_SLOT_BITS-1:0] hdr_slots;
   logic [7:0]  hdr_byte, idv, neg_sum, sum_want;
   logic        id_ignored;
   logic [3:0]  cpos, fpos;
   logic [8:0]  fwant;
   logic [10:0] sum_first, sum_last;
   logic [11:0] sum_after, spos;
   logic [CW-1:0] idx_w;
   logic [LENGTH_BITS-1:0] len;
   logic [LW-1:0] len_w;
   logic        hv, cv, sv;

   assign {counted, last, data_byte, idx} = pop_data;
   assign pop_ready = !last || !rsp_valid_ff || rsp_ready;
   assign take      = pop_valid && pop_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = result_ff;

   always_comb begin
      hl = (cfg.header_length > 3'(MAX_HEADER_BYTES)) && (MAX_HEADER_BYTES < 8) ?
           4'(MAX_HEADER_BYTES) : {1'b0, cfg.header_length};
      need = {1'b0, hl} + ((cfg.device_id_mode == scm_pkg::ID_MODE_BYTE) ? 5'd1 : 5'd0);
      hdr_slots = scm_pkg::HEADER_SLOT_BITS'(cfg.header_bytes);
      hdr_byte = hdr_slots[{idx[2:0], 3'b000} +: 8];
      id_ignored = cfg.device_id[7];
      idv = cfg.device_id & scm_pkg::DATA_MASK;
      cpos = cfg.field_positions[3:0];
      sum_first = cfg.checksum_setup[10:0];
      sum_last = cfg.checksum_setup[21:11];
      sum_after = {1'b0, sum_last} + 12'd1;
      spos = (sum_after > {1'b0, sum_first}) ? sum_after : {1'b0, sum_first};
      idx_w = CW'(idx);
      neg_sum = 8'd0 - sum_ff;
      sum_want = cfg.checksum_setup[22] ? (sum_ff & scm_pkg::DATA_MASK) :
                 (neg_sum & scm_pkg::DATA_MASK);
      fpos = '0;
      fwant = '0;

      header_match_in = header_match_ff;
      fields_match_in = fields_match_ff;
      command_seen_in = command_seen_ff;
      sum_in = sum_ff;
      sum_match_in = sum_match_ff;

      if (counted) begin
         if ((idx < LENGTH_BITS'(hl)) && (data_byte != hdr_byte)) begin
            header_match_in = 1'b0;
         end
         if ((cfg.device_id_mode == scm_pkg::ID_MODE_BYTE) && (idx == LENGTH_BITS'(hl)) &&
             !id_ignored && (data_byte != idv)) begin
            header_match_in = 1'b0;
         end
         if ((cpos != '0) && (idx == LENGTH_BITS'(cpos))) begin
            command_seen_in = 1'b1;
            if (cfg.device_id_mode == scm_pkg::ID_MODE_NIBBLE) begin
               if ((data_byte & scm_pkg::LOW_NIBBLE_MASK) != cfg.expected_cmd) begin
                  fields_match_in = 1'b0;
               end
               if (!id_ignored && ({4'b0000, data_byte[7:4]} != idv)) begin
                  header_match_in = 1'b0;
               end
            end else if (data_byte != cfg.expected_cmd) begin
               fields_match_in = 1'b0;
            end
         end
         for (int k = 0; k < 3; k++) begin
            fpos = cfg.field_positions[4*(k+1) +: 4];
            fwant = cfg.expected_fields[9*k +: 9];
            if ((fpos != '0) && !fwant[8] && (idx == LENGTH_BITS'(fpos)) &&
                (data_byte != fwant[7:0])) begin
               fields_match_in = 1'b0;
            end
         end
         if ((idx_w >= CW'(sum_first)) && (idx_w <= CW'(sum_last))) begin
            sum_in = sum_ff + data_byte;
         end
         if (idx_w == CW'(spos)) begin
            sum_match_in = (data_byte == sum_want);
         end
      end

      len = counted ? idx + 1'b1 : idx;
      len_w = LW'(len);
      hv = header_match_in && (len_w >= LW'(need));
      if ((cfg.device_id_mode == scm_pkg::ID_MODE_NIBBLE) && !id_ignored &&
          (cpos != '0) && !command_seen_in) begin
         hv = 1'b0;
      end
      cv = hv && fields_match_in && ((cpos == '0) || command_seen_in);
      sv = !cfg.checksum_setup[23] || sum_match_in;

      result_in = result_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (take && last) begin
         result_in.header_valid = hv;
         result_in.command_valid = cv;
         result_in.checksum_valid = sv;
         result_in.message_length = (len_w > LW'(scm_pkg::MAX_REPORT_LENGTH)) ?
                                    scm_pkg::MAX_REPORT_LENGTH :
                                    len_w[scm_pkg::OUT_LENGTH_BITS-1:0];
         rsp_valid_in = 1'b1;
         header_match_in = 1'b1;
         fields_match_in = 1'b1;
         command_seen_in = 1'b0;
         sum_in = '0;
         sum_match_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_match_ff <= 1'b1;
         fields_match_ff <= 1'b1;
         command_seen_ff <= 1'b0;
         sum_ff          <= '0;
         sum_match_ff    <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (take) begin
            header_match_ff <= header_match_in;
            fields_match_ff <= fields_match_in;
            command_seen_ff <= command_seen_in;
            sum_ff          <= sum_in;
            sum_match_ff    <= sum_match_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

endmodule

>>> hdl/sysex_message_checker_unit.sv
// ----------------------------------------------------------------------------
// SysEx message checker
// Checks header, device id, command fields and checksum of a SysEx message
// arriving one byte per item; one result per message on its last byte.
//
//   channel | direction | payload
//   req_    | in        | message_byte, last_byte
//   rsp_    | out       | header_valid, command_valid, checksum_valid,
//           |           | message_length
//   csr_    | in        | index, data (register write, always ready)
//
// One byte per cycle while the queue has room; the last byte passes the queue
// entry, then the registered result, before rsp_valid rises.
// Reset restores the byte count, match flags, sum and queue; registers reset
// to their defaults. A stalled result blocks only the next last byte; other
// bytes keep flowing until the queue fills.
// ----------------------------------------------------------------------------
module sysex_message_checker_unit #(
   parameter int MAX_HEADER_BYTES = 5,
   parameter int LENGTH_BITS = 11
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_message_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_header_valid,
   output logic        rsp_command_valid,
   output logic        rsp_checksum_valid,
   output logic [10:0] rsp_message_length,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [39:0] csr_data
);

   localparam int ENTRY_BITS = LENGTH_BITS + 10;

   scm_pkg::config_type cfg_ff, cfg_in;
   scm_pkg::result_type result;
   logic                  push_valid, push_ready, pop_valid, pop_ready;
   logic [ENTRY_BITS-1:0] push_data, pop_data;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (scm_pkg::reg_index_type'(csr_index))
            scm_pkg::REG_HEADER_BYTES:    cfg_in.header_bytes = csr_data;
            scm_pkg::REG_HEADER_LENGTH:   cfg_in.header_length = csr_data[2:0];
            scm_pkg::REG_DEVICE_ID_MODE:  cfg_in.device_id_mode = csr_data[1:0];
            scm_pkg::REG_DEVICE_ID:       cfg_in.device_id = csr_data[7:0];
            scm_pkg::REG_EXPECTED_CMD:    cfg_in.expected_cmd = csr_data[7:0];
            scm_pkg::REG_FIELD_POSITIONS: cfg_in.field_positions = csr_data[15:0];
            scm_pkg::REG_EXPECTED_FIELDS: cfg_in.expected_fields = csr_data[26:0];
            scm_pkg::REG_CHECKSUM_SETUP:  cfg_in.checksum_setup = csr_data[23:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= scm_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   scm_front #(
      .LENGTH_BITS(LENGTH_BITS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_message_byte(req_message_byte),
      .req_last_byte(req_last_byte),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_data(push_data)
   );

   scm_queue #(
      .WIDTH(ENTRY_BITS),
      .DEPTH(scm_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_data(push_data),
      .pop_valid(pop_valid),
      .pop_ready(pop_ready),
      .pop_data(pop_data)
   );

   scm_back #(
      .MAX_HEADER_BYTES(MAX_HEADER_BYTES),
      .LENGTH_BITS(LENGTH_BITS)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .cfg(cfg_ff),
      .pop_valid(pop_valid),
      .pop_ready(pop_ready),
      .pop_data(pop_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_result(result)
   );

   assign rsp_header_valid   = result.header_valid;
   assign rsp_command_valid  = result.command_valid;
   assign rsp_checksum_valid = result.checksum_valid;
   assign rsp_message_length = result.message_length;

endmodule

>>> hdl/scm_checker.sv
// ----------------------------------------------------------------------------
// SysEx checker port assertions
// Checks result consistency and handshake behavior seen at the top-level ports.
// ----------------------------------------------------------------------------
module scm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_header_valid,
   input logic        rsp_command_valid,
   input logic        rsp_checksum_valid,
   input logic [10:0] rsp_message_length,
   input logic        csr_valid,
   input logic        csr_ready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_message_length) &&
      $stable(rsp_header_valid) && $stable(rsp_command_valid) &&
      $stable(rsp_checksum_valid))
      else $error("result changed while stalled");

   a_cmd_needs_hdr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_command_valid || rsp_header_valid)
      else $error("command valid without header valid");

   a_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_message_length != 11'd0)
      else $error("result with zero length");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("register write stalled");

endmodule

bind sysex_message_checker_unit scm_checker u_scm_checker (.*);

>>> bench/tb_sysex_message_checker_unit.sv
// ----------------------------------------------------------------------------
// SysEx message checker testbench
// Streams SysEx messages one byte per item into the checker under a series of
// register settings. A built-in predictor works out the verdict of every
// message and compares it field by field with each result. Sender gaps,
// receiver stalls and one long receiver hold-off stress the handshakes.
// ----------------------------------------------------------------------------
module tb_sysex_message_checker_unit;

   class sysex_verdict_predictor;
      scm_pkg::config_type regs;
      int unsigned byte_index;
      bit header_ok, fields_ok, cmd_seen, sum_ok;
      logic [7:0] sum;
      scm_pkg::result_type verdicts_due[$];
      int errors;

      function new();
         regs = scm_pkg::CFG_RESET;
         errors = 0;
         restart();
      endfunction

      function void restart();
         byte_index = 0;
         header_ok = 1;
         fields_ok = 1;
         cmd_seen = 0;
         sum = '0;
         sum_ok = 0;
      endfunction

      function void write_reg(scm_pkg::reg_index_type idx,
                              logic [scm_pkg::CSR_DATA_BITS-1:0] d);
         case (idx)
            scm_pkg::REG_HEADER_BYTES: regs.header_bytes = d[39:0];
            scm_pkg::REG_HEADER_LENGTH: regs.header_length = d[2:0];
            scm_pkg::REG_DEVICE_ID_MODE: regs.device_id_mode = d[1:0];
            scm_pkg::REG_DEVICE_ID: regs.device_id = d[7:0];
            scm_pkg::REG_EXPECTED_CMD: regs.expected_cmd = d[7:0];
            scm_pkg::REG_FIELD_POSITIONS: regs.field_positions = d[15:0];
            scm_pkg::REG_EXPECTED_FIELDS: regs.expected_fields = d[26:0];
            scm_pkg::REG_CHECKSUM_SETUP: regs.checksum_setup = d[23:0];
            default: ;
         endcase
      endfunction

      function int unsigned header_span();
         return (regs.header_length > 3'd5) ? 5 : int'(regs.header_length);
      endfunction

      function void judge_byte(int unsigned idx, logic [7:0] b);
         int unsigned hl, cpos, pos, first, last_idx, spos;
         logic [8:0] want;
         logic [7:0] sum_want;
         bit id_off;
         logic [7:0] id_val;
         hl = header_span();
         cpos = int'(regs.field_positions[3:0]);
         id_off = regs.device_id[7];
         id_val = regs.device_id & scm_pkg::DATA_MASK;
         if (idx < hl && b != regs.header_bytes[8*idx +: 8])
            header_ok = 0;
         if (regs.device_id_mode == scm_pkg::ID_MODE_BYTE && idx == hl && !id_off &&
             b != id_val)
            header_ok = 0;
         if (cpos != 0 && idx == cpos) begin
            cmd_seen = 1;
            if (regs.device_id_mode == scm_pkg::ID_MODE_NIBBLE) begin
               if ((b & scm_pkg::LOW_NIBBLE_MASK) != regs.expected_cmd)
                  fields_ok = 0;
               if (!id_off && {4'h0, b[7:4]} != id_val)
                  header_ok = 0;
            end else if (b != regs.expected_cmd) begin
               fields_ok = 0;
            end
         end
         for (int k = 0; k < 3; k++) begin
            pos = int'(regs.field_positions[4*(k+1) +: 4]);
            want = regs.expected_fields[9*k +: 9];
            if (pos != 0 && !want[8] && idx == pos && b != want[7:0])
               fields_ok = 0;
         end
         first = int'(regs.checksum_setup[10:0]);
         last_idx = int'(regs.checksum_setup[21:11]);
         if (idx >= first && idx <= last_idx)
            sum = sum + b;
         spos = (last_idx + 1 > first) ? last_idx + 1 : first;
         if (idx == spos) begin
            sum_want = regs.checksum_setup[22] ? (sum & scm_pkg::DATA_MASK)
                                               : ((8'h00 - sum) & scm_pkg::DATA_MASK);
            sum_ok = (b == sum_want);
         end
      endfunction

      function void note_byte(logic [7:0] b, logic last);
         int unsigned need, cpos;
         scm_pkg::result_type v;
         if (byte_index < scm_pkg::MAX_REPORT_LENGTH) begin
            judge_byte(byte_index, b);
            byte_index++;
         end
         if (!last)
            return;
         cpos = int'(regs.field_positions[3:0]);
         need = header_span() + ((regs.device_id_mode == scm_pkg::ID_MODE_BYTE) ? 1 : 0);
         v.header_valid = header_ok && byte_index >= need;
         if (regs.device_id_mode == scm_pkg::ID_MODE_NIBBLE && !regs.device_id[7] &&
             cpos != 0 && !cmd_seen)
            v.header_valid = 0;
         v.command_valid = v.header_valid && fields_ok && (cpos == 0 || cmd_seen);
         v.checksum_valid = !regs.checksum_setup[23] || sum_ok;
         v.message_length = byte_index[scm_pkg::OUT_LENGTH_BITS-1:0];
         verdicts_due.push_back(v);
         restart();
      endfunction

      function void check_verdict(scm_pkg::result_type got);
         scm_pkg::result_type exp;
         if (verdicts_due.size() == 0) begin
            $display("%0t unexpected result %p", $time, got);
            errors++;
            return;
         end
         exp = verdicts_due.pop_front();
         if (got.header_valid !== exp.header_valid) begin
            $display("%0t header_valid expected %0b actual %0b", $time,
                     exp.header_valid, got.header_valid);
            errors++;
         end
         if (got.command_valid !== exp.command_valid) begin
            $display("%0t command_valid expected %0b actual %0b", $time,
                     exp.command_valid, got.command_valid);
            errors++;
         end
         if (got.checksum_valid !== exp.checksum_valid) begin
            $display("%0t checksum_valid expected %0b actual %0b", $time,
                     exp.checksum_valid, got.checksum_valid);
            errors++;
         end
         if (got.message_length !== exp.message_length) begin
            $display("%0t message_length expected %0d actual %0d", $time,
                     exp.message_length, got.message_length);
            errors++;
         end
      endfunction

      function int pending();
         return verdicts_due.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [7:0] req_message_byte = '0;
   logic req_last_byte = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_header_valid;
   logic rsp_command_valid;
   logic rsp_checksum_valid;
   logic [10:0] rsp_message_length;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0] csr_index = '0;
   logic [39:0] csr_data = '0;

   sysex_verdict_predictor verdicts = new();
   scm_pkg::config_type cur_cfg;
   logic [7:0] msg_bytes[$];
   scm_pkg::result_type seen;
   int burst_left = 0;
   bit idle_on = 1;
   bit hold_request = 0;
   int hold_left = 0;
   logic [15:0] stall_pattern = 16'hffff;
   int pattern_age = 0;

   sysex_message_checker_unit i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_message_byte(req_message_byte),
      .req_last_byte(req_last_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_header_valid(rsp_header_valid),
      .rsp_command_valid(rsp_command_valid),
      .rsp_checksum_valid(rsp_checksum_valid),
      .rsp_message_length(rsp_message_length),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready)
            verdicts.write_reg(scm_pkg::reg_index_type'(csr_index), csr_data);
         if (req_valid && req_ready)
            verdicts.note_byte(req_message_byte, req_last_byte);
         if (rsp_valid && rsp_ready) begin
            seen.header_valid = rsp_header_valid;
            seen.command_valid = rsp_command_valid;
            seen.checksum_valid = rsp_checksum_valid;
            seen.message_length = rsp_message_length;
            verdicts.check_verdict(seen);
         end
      end
   end

   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready = 1'b0;
      end else if (hold_request) begin
         hold_request = 0;
         hold_left = 300;
         rsp_ready = 1'b0;
      end else begin
         rsp_ready = stall_pattern[0];
         stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
         pattern_age++;
         if (pattern_age == 64) begin
            pattern_age = 0;
            case ($urandom_range(0, 2))
               0: stall_pattern = 16'hffff;
               1: stall_pattern = 16'($urandom);
               default: stall_pattern = 16'($urandom & $urandom);
            endcase
            if (stall_pattern == 0)
               stall_pattern = 16'h0001;
         end
      end
   end

   initial begin
      #(20 * 400000);
      $display("CHECK FAILED");
      $finish;
   end

   task automatic write_reg(scm_pkg::reg_index_type idx, logic [39:0] d);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = d;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic write_config(scm_pkg::config_type c);
      cur_cfg = c;
      write_reg(scm_pkg::REG_HEADER_BYTES, c.header_bytes);
      write_reg(scm_pkg::REG_HEADER_LENGTH, 40'(c.header_length));
      write_reg(scm_pkg::REG_DEVICE_ID_MODE, 40'(c.device_id_mode));
      write_reg(scm_pkg::REG_DEVICE_ID, 40'(c.device_id));
      write_reg(scm_pkg::REG_EXPECTED_CMD, 40'(c.expected_cmd));
      write_reg(scm_pkg::REG_FIELD_POSITIONS, 40'(c.field_positions));
      write_reg(scm_pkg::REG_EXPECTED_FIELDS, 40'(c.expected_fields));
      write_reg(scm_pkg::REG_CHECKSUM_SETUP, 40'(c.checksum_setup));
   endtask

   task automatic send_byte(logic [7:0] b, logic last);
      if (idle_on && burst_left == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(0, 6)) @(negedge clock);
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_valid = 1'b1;
      req_message_byte = b;
      req_last_byte = last;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic send_message();
      foreach (msg_bytes[i])
         send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
   endtask

   task automatic drain();
      req_valid = 1'b0;
      while (verdicts.pending() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // fill msg_bytes with a message built to pass the checks of cur_cfg; clashing settings can still fail it
   function automatic void build_message(int min_len);
      int hl, cpos, pos, first, last_idx, spos, len;
      logic [8:0] want;
      logic [7:0] s;
      hl = (cur_cfg.header_length > 3'd5) ? 5 : int'(cur_cfg.header_length);
      cpos = int'(cur_cfg.field_positions[3:0]);
      first = int'(cur_cfg.checksum_setup[10:0]);
      last_idx = int'(cur_cfg.checksum_setup[21:11]);
      spos = (last_idx + 1 > first) ? last_idx + 1 : first;
      len = hl + 1;
      if (cpos + 1 > len)
         len = cpos + 1;
      for (int k = 1; k < 4; k++) begin
         pos = int'(cur_cfg.field_positions[4*k +: 4]);
         if (pos + 1 > len)
            len = pos + 1;
      end
      if (cur_cfg.checksum_setup[23] && spos <= 40 && spos + 1 > len)
         len = spos + 1;
      if (min_len > len)
         len = min_len;
      msg_bytes.delete();
      for (int i = 0; i < len; i++)
         msg_bytes.push_back(8'($urandom_range(0, 255)));
      for (int i = 0; i < hl; i++)
         msg_bytes[i] = cur_cfg.header_bytes[8*i +: 8];
      if (cur_cfg.device_id_mode == scm_pkg::ID_MODE_BYTE && !cur_cfg.device_id[7])
         msg_bytes[hl] = cur_cfg.device_id & scm_pkg::DATA_MASK;
      if (cpos != 0) begin
         if (cur_cfg.device_id_mode == scm_pkg::ID_MODE_NIBBLE)
            msg_bytes[cpos] = {cur_cfg.device_id[3:0], cur_cfg.expected_cmd[3:0]};
         else
            msg_bytes[cpos] = cur_cfg.expected_cmd;
      end
      for (int k = 0; k < 3; k++) begin
         pos = int'(cur_cfg.field_positions[4*(k+1) +: 4]);
         want = cur_cfg.expected_fields[9*k +: 9];
         if (pos != 0 && !want[8])
            msg_bytes[pos] = want[7:0];
      end
      s = '0;
      for (int i = first; i <= last_idx && i < len; i++)
         s = s + msg_bytes[i];
      if (spos < len)
         msg_bytes[spos] = cur_cfg.checksum_setup[22] ? (s & scm_pkg::DATA_MASK)
                                                      : ((8'h00 - s) & scm_pkg::DATA_MASK);
   endfunction

   function automatic scm_pkg::config_type random_config();
      scm_pkg::config_type c;
      logic [3:0] p;
      c.header_bytes = 40'({$urandom, $urandom});
      c.header_length = 3'($urandom_range(0, 7));
      c.device_id_mode = ($urandom_range(0, 4) == 0) ? 2'($urandom_range(0, 3))
                                                      : 2'($urandom_range(1, 2));
      if ($urandom_range(0, 4) == 0)
         c.device_id = 8'(32'h80 | $urandom_range(0, 127));
      else if (c.device_id_mode == scm_pkg::ID_MODE_NIBBLE && $urandom_range(0, 3) != 0)
         c.device_id = 8'($urandom_range(0, 15));
      else
         c.device_id = 8'($urandom_range(0, 127));
      if (c.device_id_mode == scm_pkg::ID_MODE_NIBBLE && $urandom_range(0, 3) != 0)
         c.expected_cmd = 8'($urandom_range(0, 15));
      else
         c.expected_cmd = 8'($urandom_range(0, 255));
      for (int k = 0; k < 4; k++) begin
         p = ($urandom_range(0, 3) == 0) ? 4'd0 : 4'($urandom_range(1, 15));
         c.field_positions[4*k +: 4] = p;
      end
      c.expected_fields = 27'($urandom);
      if ($urandom_range(0, 9) == 0) begin
         c.checksum_setup = 24'($urandom);
      end else begin
         c.checksum_setup[10:0] = 11'($urandom_range(0, 10));
         c.checksum_setup[21:11] = 11'($urandom_range(0, 14));
         c.checksum_setup[22] = 1'($urandom_range(0, 1));
         c.checksum_setup[23] = ($urandom_range(0, 3) != 0);
      end
      return c;
   endfunction

   initial begin
      scm_pkg::config_type c;
      int random_bytes, phase_bytes, phase, cut;
      random_bytes = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      cur_cfg = verdicts.regs;

      // reset settings: everything passes, length only
      msg_bytes = '{8'h00};
      send_message();
      msg_bytes = '{8'hff};
      send_message();
      msg_bytes = '{8'h55, 8'haa};
      send_message();

      drain();
      c.header_bytes = 40'h00_0000_43f0;
      c.header_length = 3'd2;
      c.device_id_mode = scm_pkg::ID_MODE_BYTE;
      c.device_id = 8'h10;
      c.expected_cmd = 8'h7f;
      c.field_positions = 16'h6543;
      c.expected_fields = {9'h07f, 9'h100, 9'h001};
      c.checksum_setup = {1'b1, 1'b0, 11'd6, 11'd3};
      write_config(c);
      build_message(0);
      send_message();
      build_message(0);
      msg_bytes = msg_bytes[0:2];
      send_message();

      drain();
      c.header_bytes = 40'h00_0000_00f0;
      c.header_length = 3'd1;
      c.device_id_mode = scm_pkg::ID_MODE_NIBBLE;
      c.device_id = 8'h0a;
      c.expected_cmd = 8'h05;
      c.field_positions = 16'h0001;
      c.checksum_setup = {1'b1, 1'b1, 11'd1, 11'd2};
      write_config(c);
      build_message(0);
      send_message();
      msg_bytes = '{8'hf0};
      send_message();

      phase = 0;
      while (random_bytes < 1030) begin
         drain();
         if (phase == 0)
            c = '0;
         else if (phase == 1)
            c = '1;
         else
            c = random_config();
         write_config(c);
         idle_on = (phase % 5 != 2);
         phase_bytes = 0;
         if (phase == 3) begin
            hold_request = 1;
            repeat (16) begin
               send_byte(8'($urandom_range(0, 255)), 1'b1);
               phase_bytes++;
            end
         end
         while (phase_bytes < 26) begin
            case ($urandom_range(0, 19))
               0, 1, 2: begin
                  msg_bytes.delete();
                  repeat ($urandom_range(1, 8))
                     msg_bytes.push_back(8'($urandom_range(0, 255)));
               end
               3, 4: begin
                  build_message($urandom_range(0, 4));
                  msg_bytes[$urandom_range(0, msg_bytes.size() - 1)] ^=
                     8'($urandom_range(1, 255));
               end
               5, 6: begin
                  build_message($urandom_range(0, 4));
                  cut = $urandom_range(1, msg_bytes.size());
                  while (msg_bytes.size() > cut)
                     void'(msg_bytes.pop_back());
               end
               default: build_message($urandom_range(0, 4));
            endcase
            send_message();
            phase_bytes += msg_bytes.size();
         end
         random_bytes += phase_bytes;
         phase++;
      end

      drain();
      repeat (6) @(negedge clock);
      if (verdicts.errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
